// File: hdl/fsfl_pkg.sv
package fsfl_pkg;

    localparam int TAPS        = 256;
    localparam int TAP_W       = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int COS_W       = COEF_BITS + 1;
    localparam int RATE_W      = 20;
    localparam int CUT_W       = 19;
    localparam int BIN_W       = 7;
    localparam int NUM_W       = 27;
    localparam int DIV_W       = CUT_W + TAP_W;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + TAP_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUT  = 2'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 20'd48000;
    localparam logic [CUT_W-1:0]  CUT_RESET  = 19'd4000;

    localparam longint unsigned TAYLOR_DEN [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef logic signed [COS_W-1:0] t_cos_rom [TAPS];

    typedef enum logic [2:0] {
        S_DSTART,
        S_DIV,
        S_COEF,
        S_IDLE,
        S_MAC,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic div_start;
        logic div_step;
        logic coef_start;
        logic coef_step;
        logic accept;
        logic mac_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic div_last;
        logic coef_last;
        logic mac_last;
        logic pipe_busy;
        logic out_full;
    } t_stat;

    function automatic longint unsigned cos_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x2   = (x * x + 64'd536870912) >> 30;
        term = 64'd1073741824;
        sum  = 64'sd1073741824;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DEN[n-1];
            if (n[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        return longint'(sum);
    endfunction

    function automatic t_cos_rom build_cos_rom();
        t_cos_rom rom;
        longint unsigned u;
        longint unsigned x;
        longint unsigned c;
        logic neg;
        for (int j = 0; j < TAPS; j++) begin
            u   = 2 * j;
            neg = 1'b0;
            if (u > TAPS) u = 2 * TAPS - u;
            if (2 * u > TAPS) begin
                neg = 1'b1;
                u   = TAPS - u;
            end
            x = (u * 64'd13493037705 + 2 * TAPS) >> (TAP_W + 2);
            c = (cos_q30(x) + (64'd1 << (30 - COEF_BITS))) >> (31 - COEF_BITS);
            rom[j] = neg ? -COS_W'(c) : COS_W'(c);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

endpackage

// File: hdl/frequency_sampled_fir_lowpass.sv
// 256-tap low-pass FIR with coefficients built on chip by frequency sampling.
// After reset and after every write to sample_rate_hz (index 0) or cutoff_hz
// (index 1) the block places the cutoff bin with a 7-step restoring divider
// and then builds each coefficient with one cosine-table add per bin, with the
// input held off. Each sample then takes one multiply-accumulate per tap
// through one shared 16x18 multiplier fed from the sample and coefficient
// RAMs, between an accept state and a pipeline drain and output load. The
// next sample is taken while the previous result beat waits on the output.
module frequency_sampled_fir_lowpass (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fsfl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fsfl_pkg::RATE_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [fsfl_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [fsfl_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                   o_clipped
);

    import fsfl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    fsfl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    fsfl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample_out(o_sample_out),
        .o_clipped   (o_clipped),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// File: hdl/fsfl_ram.sv
module fsfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fsfl_ctrl.sv
module fsfl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fsfl_pkg::t_stat i_stat,
    output fsfl_pkg::t_cmd  o_cmd
);

    import fsfl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DSTART;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.coef_start = 1'b1;
                    n_state          = S_COEF;
                end
            end
            S_COEF: begin
                o_cmd.coef_step = 1'b1;
                if (i_stat.coef_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_stat.mac_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy && !i_stat.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_DSTART;
            end
        endcase
        if (i_stat.cfg_hit) begin
            n_state = S_DSTART;
        end
    end

endmodule

// File: hdl/fsfl_dp.sv
module fsfl_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fsfl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fsfl_pkg::RATE_W-1:0]           i_cfg_data,
    input  logic signed [fsfl_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [fsfl_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                  o_clipped,
    input  fsfl_pkg::t_cmd                        i_cmd,
    output fsfl_pkg::t_stat                       o_stat
);

    import fsfl_pkg::*;

    logic [RATE_W-1:0] r_rate;
    logic [CUT_W-1:0]  r_cut;

    logic [DIV_W-1:0]  r_rem;
    logic [BIN_W-1:0]  r_bin;
    logic [2:0]        r_dcnt;
    logic              r_clamp;
    logic [DIV_W-1:0]  w_dsub;
    logic              w_cfg_hit;

    logic [TAP_W-1:0]        r_ci;
    logic [BIN_W-1:0]        r_k;
    logic [TAP_W-1:0]        r_idx;
    logic signed [NUM_W-1:0] r_num;
    logic [TAP_W-1:0]        w_idx;
    logic signed [NUM_W-1:0] w_num_rnd;
    logic                    w_coef_we;

    logic [TAP_W-1:0]        r_wp;
    logic [TAP_W:0]          r_fill;
    logic [TAP_W-1:0]        r_m;
    logic                    r_v1;
    logic                    r_ok1;
    logic                    r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [SAMPLE_BITS-1:0] w_dly;
    logic signed [COEF_BITS-1:0]   w_coef;

    logic signed [ACC_W-1:0] w_sum;
    logic signed [ACC_W-COEF_BITS:0] w_y;
    logic                    w_hi;
    logic                    w_lo;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;
    logic                          r_clipped;

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == REG_RATE || i_cfg_idx == REG_CUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_cut  <= CUT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_RATE) begin
                r_rate <= i_cfg_data;
            end else if (i_cfg_idx == REG_CUT) begin
                r_cut <= i_cfg_data[CUT_W-1:0];
            end
        end
    end

    assign w_dsub = {{(DIV_W-RATE_W){1'b0}}, r_rate} << r_dcnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem   <= {r_cut, {TAP_W{1'b0}}};
            r_bin   <= '0;
            r_dcnt  <= 3'(BIN_W - 1);
            r_clamp <= ({r_cut, {TAP_W{1'b0}}} >= {r_rate, {BIN_W{1'b0}}});
        end else if (i_cmd.div_step) begin
            if (r_clamp) begin
                r_bin <= '1;
            end else if (r_rem >= w_dsub) begin
                r_rem         <= r_rem - w_dsub;
                r_bin[r_dcnt] <= 1'b1;
            end
            r_dcnt <= r_dcnt - 3'd1;
        end
    end

    assign w_idx     = r_idx + r_ci;
    assign w_num_rnd = r_num + NUM_W'(TAPS / 2);
    assign w_coef_we = i_cmd.coef_step && (r_k == r_bin);

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_start) begin
            r_ci  <= '0;
            r_k   <= '0;
            r_idx <= '0;
            r_num <= NUM_W'(1 << (COEF_BITS - 1));
        end else if (i_cmd.coef_step) begin
            if (w_coef_we) begin
                r_ci  <= r_ci + 1'b1;
                r_k   <= '0;
                r_idx <= '0;
                r_num <= NUM_W'(1 << (COEF_BITS - 1));
            end else begin
                r_k   <= r_k + 1'b1;
                r_idx <= w_idx;
                r_num <= r_num + {{(NUM_W-COS_W-1){COS_ROM[w_idx][COS_W-1]}},
                                  COS_ROM[w_idx], 1'b0};
            end
        end
    end

    fsfl_ram #(
        .WIDTH(COEF_BITS),
        .DEPTH(TAPS)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_coef_we),
        .i_waddr(r_ci),
        .i_wdata(w_num_rnd[TAP_W +: COEF_BITS]),
        .i_raddr(~r_m),
        .o_rdata(w_coef)
    );

    fsfl_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(TAPS)
    ) u_dly_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept),
        .i_waddr(r_wp),
        .i_wdata(i_sample_in),
        .i_raddr(r_wp - r_m),
        .o_rdata(w_dly)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_step;
            r_v2 <= r_v1;
            if (i_cmd.accept && r_fill != (TAP_W+1)'(TAPS)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.finish) begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_m   <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.mac_step) begin
                r_m <= r_m + 1'b1;
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        r_ok1  <= ({1'b0, r_m} < r_fill);
        r_prod <= r_ok1 ? (PROD_W'(w_dly) * PROD_W'(w_coef)) : '0;
    end

    assign w_sum = r_acc + ACC_W'(1 << (COEF_BITS - 2));
    assign w_y   = w_sum[ACC_W-1:COEF_BITS-1];
    assign w_hi  = w_y > (ACC_W-COEF_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    assign w_lo  = w_y < -(ACC_W-COEF_BITS+1)'(1 << (SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_clipped <= w_hi || w_lo;
            if (w_hi) begin
                r_sample_out <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end else if (w_lo) begin
                r_sample_out <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end else begin
                r_sample_out <= w_y[SAMPLE_BITS-1:0];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

    always_comb begin
        o_stat.cfg_hit   = w_cfg_hit;
        o_stat.div_last  = r_clamp || (r_dcnt == 3'd0);
        o_stat.coef_last = (r_k == r_bin) && (r_ci == '1);
        o_stat.mac_last  = (r_m == '1);
        o_stat.pipe_busy = r_v1 || r_v2;
        o_stat.out_full  = r_out_valid;
    end

endmodule

// File: bench/frequency_sampled_fir_lowpass_tb.sv
module frequency_sampled_fir_lowpass_tb;
    import fsfl_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int NPHASE      = 7;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] y;
        bit                            clip;
    } t_row;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] y;
        bit                            clip;
    } t_beat;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx = '0;
    logic [RATE_W-1:0]             i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [SAMPLE_BITS-1:0] i_sample_in = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_clipped;

    frequency_sampled_fir_lowpass dut (.*);

    always #10 i_clk = ~i_clk;

    longint                        cos_tab [TAPS];
    longint                        taps_q [TAPS];
    logic signed [SAMPLE_BITS-1:0] history [TAPS];
    int unsigned                   head;
    logic [RATE_W-1:0]             rate_hz;
    logic [CUT_W-1:0]              cut_hz;
    t_beat                         pending [$];
    int                            errors = 0;
    int                            quiet = 0;
    bit                            out_fire = 0;
    int                            out_stall = 0;
    bit                            free_out = 0;
    bit                            free_in = 0;

    function automatic longint unsigned taylor_cos(longint unsigned x);
        longint unsigned x2, term;
        longint          acc;
        x2   = (x * x + 64'd536870912) >> 30;
        term = 64'd1073741824;
        acc  = 64'sd1073741824;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'sd1073741824) acc = 64'sd1073741824;
        return longint'(acc);
    endfunction

    function automatic void fill_cos_tab();
        longint unsigned u, x, c;
        bit              neg;
        for (int j = 0; j < TAPS; j++) begin
            u   = 2 * j;
            neg = 0;
            if (u > TAPS) u = 2 * TAPS - u;
            if (2 * u > TAPS) begin
                neg = 1;
                u   = TAPS - u;
            end
            x = (u * 64'd13493037705 + 2 * TAPS) / (4 * TAPS);
            c = (taylor_cos(x) + 64'd4096) >> 13;
            cos_tab[j] = neg ? -longint'(c) : longint'(c);
        end
    endfunction

    function automatic void rebuild_taps();
        longint unsigned b;
        longint          num;
        int unsigned     k_idx;
        if (rate_hz == 0) b = TAPS / 2 - 1;
        else b = (64'd256 * cut_hz) / rate_hz;
        if (b > TAPS / 2 - 1) b = TAPS / 2 - 1;
        for (int i = 0; i < TAPS; i++) begin
            num   = 64'sd131072;
            k_idx = 0;
            for (int k = 1; k <= int'(b); k++) begin
                k_idx = (k_idx + i) % TAPS;
                num += 2 * cos_tab[k_idx];
            end
            taps_q[i] = (num + 128) >>> 8;
        end
    endfunction

    function automatic t_beat filter_sample(logic signed [SAMPLE_BITS-1:0] x);
        longint acc;
        longint y;
        t_beat  r;
        history[head] = x;
        acc = 0;
        for (int m = 0; m < TAPS; m++)
            acc += longint'(history[(head - m) & (TAPS - 1)]) * taps_q[TAPS - 1 - m];
        head = (head + 1) % TAPS;
        y      = (acc + 64'sd65536) >>> 17;
        r.clip = 0;
        if (y > 32767) begin
            y = 32767;
            r.clip = 1;
        end else if (y < -32768) begin
            y = -32768;
            r.clip = 1;
        end
        r.y = y[SAMPLE_BITS-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_RATE) rate_hz = data;
        else if (idx == REG_CUT) cut_hz = data[CUT_W-1:0];
        else return;
        rebuild_taps();
    endtask

    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] x, input bit typed,
                             input t_beat want);
        int    gap;
        t_beat got;
        gap = free_in ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_sample_in = x;
        do @(posedge i_clk); while (!o_in_ready);
        got = filter_sample(x);
        if (typed) got = want;
        pending = {pending, got};
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending.size() == 0);
        repeat (300) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (out_fire) begin
            out_fire  = 0;
            out_stall = free_out ? 0 : $urandom_range(0, 16);
        end
        i_out_ready <= (out_stall == 0);
        if (out_stall > 0) out_stall--;
    end

    always @(posedge i_clk) begin
        t_beat exp_beat;
        quiet++;
        if (i_in_valid && o_in_ready) quiet = 0;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            quiet    = 0;
            out_fire = 1;
            if (pending.size() == 0) begin
                $error("unexpected beat: sample_out %0d clipped %0b", o_sample_out, o_clipped);
                errors++;
            end else begin
                exp_beat = pending.pop_front();
                if (o_sample_out !== exp_beat.y) begin
                    $error("sample_out: expected %0d, got %0d", exp_beat.y, o_sample_out);
                    errors++;
                end
                if (o_clipped !== exp_beat.clip) begin
                    $error("clipped: expected %0b, got %0b", exp_beat.clip, o_clipped);
                    errors++;
                end
            end
        end
        if (quiet >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    t_row directed [12] = '{
        '{16'sd0, 1, 16'sd0, 0},
        '{16'sd0, 1, 16'sd0, 0},
        '{16'sd32767, 0, 16'sd0, 0},
        '{-16'sd32768, 0, 16'sd0, 0},
        '{16'sd1, 0, 16'sd0, 0},
        '{-16'sd1, 0, 16'sd0, 0},
        '{16'sh5555, 0, 16'sd0, 0},
        '{16'shAAAA, 0, 16'sd0, 0},
        '{16'sd32767, 0, 16'sd0, 0},
        '{16'sd32767, 0, 16'sd0, 0},
        '{-16'sd32768, 0, 16'sd0, 0},
        '{16'sd0, 0, 16'sd0, 0}
    };

    int phase_items [NPHASE] = '{140, 300, 120, 160, 140, 170, 160};

    initial begin
        t_beat                         want;
        logic signed [SAMPLE_BITS-1:0] x;
        int                            sent, run, kind;
        fill_cos_tab();
        rate_hz = RATE_RESET;
        cut_hz  = CUT_RESET;
        rebuild_taps();
        head = 0;
        for (int i = 0; i < TAPS; i++) history[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r]) begin
            want.y    = directed[r].y;
            want.clip = directed[r].clip;
            send_beat(directed[r].smp, directed[r].typed, want);
        end

        for (int ph = 0; ph < NPHASE; ph++) begin
            if (ph > 0) drain();
            case (ph)
                1: write_reg(REG_RATE, 20'd0);
                2: begin
                    write_reg(REG_RATE, 20'd48000);
                    write_reg(REG_CUT, 20'd0);
                end
                3: begin
                    write_reg(REG_RATE, 20'd1000000);
                    write_reg(REG_CUT, 20'd500000);
                end
                4: begin
                    write_reg(REG_RATE, 20'hFFFFF);
                    write_reg(REG_CUT, 20'hFFFFF);
                end
                5: begin
                    write_reg(2'd2, 20'd5);
                    write_reg(2'd3, 20'd7);
                    write_reg(REG_RATE, 20'd44100);
                    write_reg(REG_CUT, 20'd3000);
                end
                6: begin
                    write_reg(REG_RATE, 20'd96000);
                    write_reg(REG_CUT, 20'd20000);
                end
                default: ;
            endcase
            free_in  = ($urandom_range(0, 3) == 0);
            free_out = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < phase_items[ph]) begin
                kind = (ph == 1 && sent == 0) ? 0 : $urandom_range(0, 3);
                run  = (kind == 0) ? 280 : 20;
                for (int k = 0; k < run && sent < phase_items[ph]; k++) begin
                    if (kind == 0) begin
                        // match signs to the taps so the sum peaks at the wrap
                        x = (taps_q[head] >= 0) ? 16'sd32767 : -16'sd32768;
                    end else begin
                        case ($urandom_range(0, 3))
                            0: x = $urandom_range(0, 400) - 200;
                            1: x = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                            default: x = $urandom();
                        endcase
                    end
                    send_beat(x, 0, want);
                    sent++;
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (pending.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
